### sv/lkod_pkg.sv
package lkod_pkg;

  localparam int NUM_LOCKS   = 64;
  localparam int STACK_DEPTH = 16;

  localparam int ID_W     = 6;
  localparam int STATUS_W = 3;
  localparam int NODE_W   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int SP_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DEADLOCK    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REL_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REL_NOT_TOP = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd4;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] lock_id;
  } lkod_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     edge_from;
    logic [ID_W-1:0]     edge_to;
    logic                edge_added;
  } lkod_out_t;

  typedef struct packed {
    logic load;
    logic rd_top;
    logic chk;
    logic srch;
    logic finish;
  } lkod_cmd_t;

  typedef struct packed {
    logic cand;
    logic known;
    logic srch_done;
  } lkod_stat_t;

endpackage

### sv/lkod_ctrl.sv
module lkod_ctrl import lkod_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  input  lkod_stat_t dp_stat,
  output logic       in_stall,
  output logic       out_valid,
  output lkod_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ROWCHK = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (dp_stat.cand) begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_ROWCHK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_ROWCHK: begin
        cmd.chk   = 1'b1;
        state_nxt = dp_stat.known ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        if (dp_stat.srch_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.srch = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/lkod_dp.sv
module lkod_dp import lkod_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lkod_cmd_t  cmd,
  input  lkod_in_t   in_data,
  output lkod_stat_t dp_stat,
  output lkod_out_t  out_data
);

  // Item under work and the held-lock stack.
  lkod_in_t             item_r;
  logic [ID_W-1:0]      stack_r [STACK_DEPTH];
  logic [CNT_W-1:0]     count_r, count_nxt;

  // Order graph: one successor row per lock, with a valid bit per row.
  logic [NUM_LOCKS-1:0] mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] row_ok_r;
  logic [NUM_LOCKS-1:0] rd_data_r;
  logic                 rd_ok_r;

  // Reachability walk.
  logic [NUM_LOCKS-1:0] reach_r, reach_nxt;
  logic [NUM_LOCKS-1:0] pend_r, pend_nxt;
  logic                 infl_r, infl_nxt;
  logic [NUM_LOCKS-1:0] edge_row_r;
  logic                 known_r;
  lkod_out_t            out_r, out_nxt;

  logic [ID_W-1:0]      id;
  logic [NODE_W-1:0]    id_node;
  logic                 id_ok;
  logic                 empty, full;
  logic [CNT_W-1:0]     top_cnt;
  logic [SP_W-1:0]      top_idx;
  logic [ID_W-1:0]      top;
  logic [NODE_W-1:0]    top_node;
  logic                 top_ok;
  logic                 cand;
  logic [NUM_LOCKS-1:0] row_data;
  logic [NUM_LOCKS-1:0] id_onehot;
  logic [NODE_W-1:0]    pick;
  logic                 pick_any;
  logic                 found;
  logic                 mem_re, mem_we;
  logic [NODE_W-1:0]    rd_addr;
  logic                 push, pop;

  assign id        = item_r.lock_id;
  assign id_node   = id[NODE_W-1:0];
  assign id_ok     = ({1'b0, id} < (ID_W + 1)'(NUM_LOCKS));
  assign id_onehot = NUM_LOCKS'(1) << id_node;

  assign empty    = (count_r == '0);
  assign full     = (count_r >= CNT_W'(STACK_DEPTH));
  assign top_cnt  = count_r - CNT_W'(1);
  assign top_idx  = top_cnt[SP_W-1:0];
  assign top      = stack_r[top_idx];
  assign top_node = top[NODE_W-1:0];
  assign top_ok   = ({1'b0, top} < (ID_W + 1)'(NUM_LOCKS));

  assign cand = (item_r.mode == MODE_ACQUIRE) && !full && !empty && (top != id) &&
                id_ok && top_ok;

  assign row_data = rd_ok_r ? rd_data_r : '0;
  assign found    = reach_r[top_node];

  assign dp_stat.cand      = cand;
  assign dp_stat.known     = row_data[id_node];
  assign dp_stat.srch_done = found || ((pend_r == '0) && !infl_r);

  // Lowest pending node is expanded next.
  always_comb begin
    pick     = '0;
    pick_any = 1'b0;
    for (int n = NUM_LOCKS - 1; n >= 0; n--) begin
      if (pend_r[n]) begin
        pick     = NODE_W'(n);
        pick_any = 1'b1;
      end
    end
  end

  assign rd_addr = cmd.rd_top ? top_node : pick;
  assign mem_re  = cmd.rd_top || (cmd.srch && pick_any);
  assign mem_we  = cmd.finish && cand && !known_r && !found;

  // Each search cycle issues one row read and merges the row read the cycle before.
  always_comb begin
    reach_nxt = reach_r;
    pend_nxt  = pend_r;
    infl_nxt  = infl_r;
    if (cmd.chk) begin
      reach_nxt = id_onehot;
      pend_nxt  = id_onehot;
      infl_nxt  = 1'b0;
    end else if (cmd.srch) begin
      if (pick_any) begin
        pend_nxt = pend_nxt & ~(NUM_LOCKS'(1) << pick);
      end
      if (infl_r) begin
        reach_nxt = reach_r | row_data;
        pend_nxt  = pend_nxt | (row_data & ~reach_r);
      end
      infl_nxt = pick_any;
    end
  end

  assign push = (item_r.mode == MODE_ACQUIRE) && !full;
  assign pop  = (item_r.mode == MODE_RELEASE) && !empty && (top == id);

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish && push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.finish && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (item_r.mode == MODE_RELEASE) begin
      if (empty) begin
        out_nxt.status = STAT_REL_EMPTY;
      end else if (top != id) begin
        out_nxt.status = STAT_REL_NOT_TOP;
      end else begin
        out_nxt.status = STAT_OK;
      end
    end else if (full) begin
      out_nxt.status = STAT_FULL;
    end else if (cand && !known_r) begin
      out_nxt.edge_from  = top;
      out_nxt.edge_to    = id;
      out_nxt.status     = found ? STAT_DEADLOCK : STAT_OK;
      out_nxt.edge_added = !found;
    end else begin
      out_nxt.status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      row_ok_r <= '0;
      rd_ok_r  <= 1'b0;
      infl_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      infl_r  <= infl_nxt;
      if (mem_we) begin
        row_ok_r[top_node] <= 1'b1;
      end
      if (mem_re) begin
        rd_ok_r <= row_ok_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[top_node] <= edge_row_r | id_onehot;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    reach_r <= reach_nxt;
    pend_r  <= pend_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.chk) begin
      known_r    <= row_data[id_node];
      edge_row_r <= row_data;
    end
    if (cmd.finish && push) begin
      stack_r[count_r[SP_W-1:0]] <= id;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### sv/lock_order_cycle_detector.sv
// A transaction passes from IDLE through DECIDE to FINISH when no order edge is considered,
// also through ROWCHK when the edge is already known, and through ROWCHK and SEARCH when a
// cycle search expands the reached nodes. One transaction is in flight at a time: the next
// is accepted the cycle after the result is loaded into the output register. Synchronous
// active-low reset empties the stack and clears all order edges at once through per-row
// valid bits.
module lock_order_cycle_detector import lkod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lkod_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lkod_out_t out_data
);

  lkod_cmd_t  cmd;
  lkod_stat_t dp_stat;

  lkod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lkod_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .dp_stat  (dp_stat),
    .out_data (out_data)
  );

endmodule

### tb/lkod_checker.sv
`timescale 1ns / 1ps

module lkod_checker import lkod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  lkod_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  lkod_out_t out_data,
  output int        fail_count,
  output int        pending_results
);

  logic [NUM_LOCKS-1:0] succ_rows [NUM_LOCKS];
  logic [ID_W-1:0]      held_locks [STACK_DEPTH];
  int unsigned          held_cnt;
  lkod_out_t            expected_verdicts [$];
  int                   results_seen;

  initial begin
    for (int n = 0; n < NUM_LOCKS; n++) succ_rows[n] = '0;
    held_cnt        = 0;
    results_seen    = 0;
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Forward closure from src; true when dst is among the reached nodes.
  function automatic logic reachable(input int unsigned src, input int unsigned dst);
    logic [NUM_LOCKS-1:0] seen;
    logic [NUM_LOCKS-1:0] grown;
    seen      = '0;
    seen[src] = 1'b1;
    for (int r = 0; r < NUM_LOCKS; r++) begin
      grown = seen;
      for (int n = 0; n < NUM_LOCKS; n++) begin
        if (seen[n]) grown |= succ_rows[n];
      end
      if (grown == seen) break;
      seen = grown;
    end
    return seen[dst];
  endfunction

  function automatic lkod_out_t apply_lock_op(input lkod_in_t op);
    lkod_out_t       res;
    logic [ID_W-1:0] top_id;
    res        = '0;
    res.status = STAT_OK;
    if (op.mode == MODE_ACQUIRE) begin
      if (held_cnt >= STACK_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        if (held_cnt > 0) begin
          top_id = held_locks[held_cnt-1];
          if (top_id != op.lock_id && top_id < NUM_LOCKS && op.lock_id < NUM_LOCKS &&
              !succ_rows[top_id][op.lock_id]) begin
            res.edge_from = top_id;
            res.edge_to   = op.lock_id;
            // The graph stays acyclic, so a path back from the new lock means a deadlock.
            if (reachable(op.lock_id, top_id)) begin
              res.status = STAT_DEADLOCK;
            end else begin
              succ_rows[top_id][op.lock_id] = 1'b1;
              res.edge_added = 1'b1;
            end
          end
        end
        held_locks[held_cnt] = op.lock_id;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        res.status = STAT_REL_EMPTY;
      end else if (held_locks[held_cnt-1] != op.lock_id) begin
        res.status = STAT_REL_NOT_TOP;
      end else begin
        held_cnt--;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lkod_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_verdicts.push_back(apply_lock_op(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                      results_seen, out_data.status, want.status));
          if (out_data.edge_from !== want.edge_from)
            report_mismatch($sformatf("result %0d edge_from: got %0d, expected %0d",
                                      results_seen, out_data.edge_from, want.edge_from));
          if (out_data.edge_to !== want.edge_to)
            report_mismatch($sformatf("result %0d edge_to: got %0d, expected %0d",
                                      results_seen, out_data.edge_to, want.edge_to));
          if (out_data.edge_added !== want.edge_added)
            report_mismatch($sformatf("result %0d edge_added: got %0d, expected %0d",
                                      results_seen, out_data.edge_added, want.edge_added));
        end
      end
      pending_results = expected_verdicts.size();
    end
  end

endmodule

### tb/tb_lock_order_cycle_detector.sv
`timescale 1ns / 1ps

module tb_lock_order_cycle_detector;
  import lkod_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  lkod_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  lkod_out_t out_data;
  logic      hold_off  = 1'b0;

  int fail_count;
  int pending_results;
  int sent_count    = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 81;

  logic [ID_W-1:0] held_shadow [$];

  lock_order_cycle_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lkod_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Long receiver hold-off while the sender keeps offering, so the block backs up.
  initial begin
    wait (sent_count >= 900);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_op(input logic mode, input logic [ID_W-1:0] id);
    lkod_in_t item;
    item.mode    = mode;
    item.lock_id = id;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= (ID_W + 1)'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic acquire_lock(input logic [ID_W-1:0] id);
    send_op(MODE_ACQUIRE, id);
    if (held_shadow.size() < STACK_DEPTH) held_shadow.push_back(id);
  endtask

  task automatic release_lock(input logic [ID_W-1:0] id);
    send_op(MODE_RELEASE, id);
    if (held_shadow.size() > 0 && held_shadow[$] == id) void'(held_shadow.pop_back());
  endtask

  // Nesting episode or lone random op: acquire locks, then unwind in LIFO order.
  task automatic run_episode();
    int              pick;
    int              pattern;
    int              depth;
    int              base;
    int              stride;
    int              keep;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 1)) acquire_lock(ID_W'($urandom));
      else release_lock(ID_W'($urandom));
      return;
    end
    pattern = $urandom_range(0, 3);
    base    = $urandom_range(0, NUM_LOCKS - 1);
    stride  = $urandom_range(1, 3);
    depth   = ($urandom_range(0, 9) == 0) ? $urandom_range(12, STACK_DEPTH + 2)
                                          : $urandom_range(1, 6);
    for (int k = 0; k < depth; k++) begin
      case (pattern)
        0:       id = ID_W'(base + k * stride);
        1:       id = ID_W'(base - k * stride);
        2:       id = ID_W'(base + $urandom_range(0, 5));
        default: id = ID_W'($urandom);
      endcase
      acquire_lock(id);
    end
    if ($urandom_range(0, 9) == 0 && held_shadow.size() > 0)
      release_lock(held_shadow[$] ^ ID_W'($urandom_range(1, 63)));
    keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, held_shadow.size()) : 0;
    while (held_shadow.size() > keep) release_lock(held_shadow[$]);
    if (held_shadow.size() == 0 && $urandom_range(0, 19) == 0) release_lock(ID_W'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Releases on an empty stack, same-lock reacquire, wrong release,
    // a deadlock, an already-known edge, then a stack filled past its depth.
    release_lock(0);
    release_lock(63);
    acquire_lock(0);
    acquire_lock(63);
    acquire_lock(63);
    release_lock(0);
    release_lock(63);
    release_lock(63);
    release_lock(0);
    acquire_lock(63);
    acquire_lock(0);
    release_lock(0);
    release_lock(63);
    acquire_lock(0);
    acquire_lock(63);
    repeat (STACK_DEPTH - 2) acquire_lock(63);
    acquire_lock(42);

    while (sent_count < 420) run_episode();
    drain_results();

    @(posedge clk);
    send_idle_pct = 81;
    recv_idle_pct = 26;
    while (sent_count < 840) run_episode();
    drain_results();

    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_count < 1250) run_episode();
    drain_results();

    repeat (100) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
